// ===== hw/rtl/accessory_attach_debounce_fsm_macros.svh =====
// Assertion macros for the accessory attach debounce block.
// Each macro takes a label, an antecedent, a consequent and a message; clk_i and rst_ni
// are in scope.
`ifndef ACCESSORY_ATTACH_DEBOUNCE_FSM_MACROS_SVH
`define ACCESSORY_ATTACH_DEBOUNCE_FSM_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define AADF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define AADF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aadf_pkg.sv =====
// Package for the accessory attach debounce block: threshold set, verdict and
// result structs, phase codes, one-hot state enum and register indexes. No dependencies.
`timescale 1ns / 1ps

package aadf_pkg;

  localparam int unsigned MvW  = 12;
  localparam int unsigned IdxW = 3;

  typedef logic [MvW-1:0] mv_t;

  // Register indexes of the configuration port
  typedef enum logic [IdxW-1:0] {
    REG_WINDOW_LOW    = 3'd0,
    REG_WINDOW_HIGH   = 3'd1,
    REG_UNPWR_SENSE   = 3'd2,
    REG_PWR_LEVEL     = 3'd3,
    REG_PWR_SENSE     = 3'd4,
    REG_RM_LEVEL      = 3'd5,
    REG_RM_SENSE      = 3'd6
  } reg_idx_e;

  // Threshold reset values
  localparam mv_t WindowLowRst   = 12'd300;
  localparam mv_t WindowHighRst  = 12'd800;
  localparam mv_t UnpwrSenseRst  = 12'd5;
  localparam mv_t PwrLevelRst    = 12'd2800;
  localparam mv_t PwrSenseRst    = 12'd2;
  localparam mv_t RmLevelRst     = 12'd2300;
  localparam mv_t RmSenseRst     = 12'd10;

  typedef struct packed {
    mv_t window_low_mv;
    mv_t window_high_mv;
    mv_t unpowered_sense_max_mv;
    mv_t powered_level_min_mv;
    mv_t powered_sense_min_mv;
    mv_t removed_level_min_mv;
    mv_t removed_sense_max_mv;
  } cfg_t;

  // Outcome of the attach and detach tests for one sample
  typedef struct packed {
    logic attach;
    logic detach;
  } verdict_t;

  // Phase codes as seen on the result stream
  localparam logic [1:0] PhDetached = 2'd0;
  localparam logic [1:0] PhAttDeb   = 2'd1;
  localparam logic [1:0] PhAttached = 2'd2;
  localparam logic [1:0] PhDetDeb   = 2'd3;

  typedef enum logic [3:0] {
    ST_DETACHED = 4'b0001,
    ST_ATT_DEB  = 4'b0010,
    ST_ATTACHED = 4'b0100,
    ST_DET_DEB  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0] phase;
    logic       supply_on;
    logic       supply_changed;
    logic       fast_poll;
  } result_t;

  function automatic logic [1:0] phase_code(state_e st);
    logic [1:0] code;
    code = PhDetached;
    case (st)
      ST_DETACHED: code = PhDetached;
      ST_ATT_DEB:  code = PhAttDeb;
      ST_ATTACHED: code = PhAttached;
      ST_DET_DEB:  code = PhDetDeb;
      default:     code = PhDetached;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/aadf_cfg_regs.sv =====
// Threshold register file of the accessory attach debounce block.
// Depends on aadf_pkg.
`timescale 1ns / 1ps

module aadf_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [aadf_pkg::IdxW-1:0] wr_idx_i,
  input  aadf_pkg::mv_t             wr_data_i,
  output aadf_pkg::cfg_t            cfg_o
);

  aadf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (aadf_pkg::reg_idx_e'(wr_idx_i))
        aadf_pkg::REG_WINDOW_LOW:  cfg_d.window_low_mv          = wr_data_i;
        aadf_pkg::REG_WINDOW_HIGH: cfg_d.window_high_mv         = wr_data_i;
        aadf_pkg::REG_UNPWR_SENSE: cfg_d.unpowered_sense_max_mv = wr_data_i;
        aadf_pkg::REG_PWR_LEVEL:   cfg_d.powered_level_min_mv   = wr_data_i;
        aadf_pkg::REG_PWR_SENSE:   cfg_d.powered_sense_min_mv   = wr_data_i;
        aadf_pkg::REG_RM_LEVEL:    cfg_d.removed_level_min_mv   = wr_data_i;
        aadf_pkg::REG_RM_SENSE:    cfg_d.removed_sense_max_mv   = wr_data_i;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low_mv          <= aadf_pkg::WindowLowRst;
      cfg_q.window_high_mv         <= aadf_pkg::WindowHighRst;
      cfg_q.unpowered_sense_max_mv <= aadf_pkg::UnpwrSenseRst;
      cfg_q.powered_level_min_mv   <= aadf_pkg::PwrLevelRst;
      cfg_q.powered_sense_min_mv   <= aadf_pkg::PwrSenseRst;
      cfg_q.removed_level_min_mv   <= aadf_pkg::RmLevelRst;
      cfg_q.removed_sense_max_mv   <= aadf_pkg::RmSenseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/aadf_detect.sv =====
// Attach and detach threshold tests for one registered sample.
// Depends on aadf_pkg.
`timescale 1ns / 1ps

module aadf_detect (
  input  aadf_pkg::mv_t      level_mv_i,
  input  aadf_pkg::mv_t      sense_mv_i,
  input  logic               bad_i,
  input  logic               supply_on_i,
  input  aadf_pkg::cfg_t     cfg_i,
  output aadf_pkg::verdict_t verdict_o
);

  logic att_powered, att_unpowered, det_raw;

  assign att_powered   = (level_mv_i >= cfg_i.powered_level_min_mv) &&
                         (sense_mv_i >= cfg_i.powered_sense_min_mv);
  assign att_unpowered = (level_mv_i >= cfg_i.window_low_mv) &&
                         (level_mv_i <= cfg_i.window_high_mv) &&
                         (sense_mv_i <= cfg_i.unpowered_sense_max_mv);
  assign det_raw       = (level_mv_i >= cfg_i.removed_level_min_mv) &&
                         (sense_mv_i <= cfg_i.removed_sense_max_mv);

  // A failed read on either pin vetoes both tests
  assign verdict_o.attach = !bad_i && (supply_on_i ? att_powered : att_unpowered);
  assign verdict_o.detach = !bad_i && det_raw;

endmodule

// ===== hw/rtl/aadf_fsm.sv =====
// Attach/detach debounce state machine with supply enable and poll interval.
// Depends on aadf_pkg.
`timescale 1ns / 1ps

module aadf_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  aadf_pkg::verdict_t verdict_i,
  output logic               supply_on_o,
  output aadf_pkg::result_t  result_o
);

  aadf_pkg::state_e state_q, state_d;
  logic supply_q, supply_d;
  logic fast_q, fast_d;
  logic changed;

  always_comb begin
    state_d  = state_q;
    supply_d = supply_q;
    fast_d   = fast_q;
    changed  = 1'b0;
    case (state_q)
      aadf_pkg::ST_DETACHED: begin
        if (verdict_i.attach) begin
          state_d = aadf_pkg::ST_ATT_DEB;
          fast_d  = 1'b1;
        end
      end
      aadf_pkg::ST_ATT_DEB: begin
        if (verdict_i.attach) begin
          state_d  = aadf_pkg::ST_ATTACHED;
          fast_d   = 1'b0;
          supply_d = 1'b1;
          changed  = 1'b1;
        end else if (verdict_i.detach) begin
          state_d = aadf_pkg::ST_DETACHED;
          fast_d  = 1'b0;
        end
      end
      aadf_pkg::ST_ATTACHED: begin
        if (verdict_i.detach) begin
          state_d = aadf_pkg::ST_DET_DEB;
          fast_d  = 1'b1;
        end
      end
      aadf_pkg::ST_DET_DEB: begin
        if (verdict_i.detach) begin
          state_d  = aadf_pkg::ST_DETACHED;
          fast_d   = 1'b0;
          supply_d = 1'b0;
          changed  = 1'b1;
        end else if (verdict_i.attach) begin
          state_d = aadf_pkg::ST_ATTACHED;
          fast_d  = 1'b0;
        end
      end
      default: begin
        state_d = aadf_pkg::ST_DETACHED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aadf_pkg::ST_DETACHED;
      supply_q <= 1'b0;
      fast_q   <= 1'b0;
    end else if (adv_i) begin
      state_q  <= state_d;
      supply_q <= supply_d;
      fast_q   <= fast_d;
    end
  end

  assign supply_on_o             = supply_q;
  assign result_o.phase          = aadf_pkg::phase_code(state_d);
  assign result_o.supply_on      = supply_d;
  assign result_o.supply_changed = changed;
  assign result_o.fast_poll      = fast_d;

endmodule

// ===== hw/rtl/accessory_attach_debounce_fsm.sv =====
// Accessory attach/detach debounce machine with supply enable, top level.
// Registers: input register, then result register; the state update sits between them.
// Throughput: one sample per cycle while the result stream is not stalled.
// Reset (rst_ni low, async): detached, supply off, default poll, thresholds to defaults.
// Depends on aadf_pkg, aadf_cfg_regs, aadf_detect, aadf_fsm and the macros header.
`timescale 1ns / 1ps
`include "accessory_attach_debounce_fsm_macros.svh"

module accessory_attach_debounce_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Sample stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // [11:0] level_mv, [23:12] sense_mv
  input  logic [1:0]                s_axis_tuser,  // [0] level_bad, [1] sense_bad
  // Result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [1:0] phase, [2] supply_on, [3] supply_changed, [4] fast_poll, [7:5] zero
  output logic [7:0]                m_axis_tdata,
  // Threshold write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [aadf_pkg::IdxW-1:0] cfg_index_i,
  input  logic [11:0]               cfg_data_i
);

  // ---------------------------------------------------------------------
  // Input register: hold one sample until the result side can take it.
  // ---------------------------------------------------------------------
  logic          in_valid_q, in_valid_d;
  aadf_pkg::mv_t level_q, sense_q;
  logic          bad_q;
  logic          adv;          // sample leaves the input register this cycle
  logic          out_free;     // result register empty or being drained

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload needs no reset; capture on every input transfer.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      level_q <= s_axis_tdata[11:0];
      sense_q <= s_axis_tdata[23:12];
      bad_q   <= s_axis_tuser[0] | s_axis_tuser[1];
    end
  end

  // ---------------------------------------------------------------------
  // Thresholds. Writes are always taken and land at once; issue them only
  // while no sample is in flight.
  // ---------------------------------------------------------------------
  aadf_pkg::cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  aadf_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // ---------------------------------------------------------------------
  // Threshold tests and state update: the single combinational pass.
  // The attach window depends on the current supply state.
  // ---------------------------------------------------------------------
  aadf_pkg::verdict_t verdict;
  aadf_pkg::result_t  res_d;
  logic               supply_q;

  aadf_detect u_detect (
    .level_mv_i  (level_q),
    .sense_mv_i  (sense_q),
    .bad_i       (bad_q),
    .supply_on_i (supply_q),
    .cfg_i       (cfg),
    .verdict_o   (verdict)
  );

  aadf_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .verdict_i   (verdict),
    .supply_on_o (supply_q),
    .result_o    (res_d)
  );

  // ---------------------------------------------------------------------
  // Result register: load on advance, drop when the consumer takes it.
  // ---------------------------------------------------------------------
  logic              out_valid_q, out_valid_d;
  aadf_pkg::result_t res_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.fast_poll, res_q.supply_changed,
                          res_q.supply_on, res_q.phase};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic no_confirm, fast_ok, confirm_seen, confirm_ok;

  assign no_confirm   = adv && !res_d.supply_changed;
  assign fast_ok      = res_q.fast_poll == ((res_q.phase == aadf_pkg::PhAttDeb) ||
                                            (res_q.phase == aadf_pkg::PhDetDeb));
  assign confirm_seen = out_valid_q && res_q.supply_changed;
  assign confirm_ok   = res_q.supply_on == (res_q.phase == aadf_pkg::PhAttached);

  // Supply may only move on a sample that confirms attach or detach.
  `AADF_ASSERT_NEXT(a_supply_only_on_confirm, no_confirm, $stable(supply_q), "supply moved")
  // Short poll interval is selected exactly in the debounce phases.
  `AADF_ASSERT_SAME(a_fast_matches_phase, out_valid_q, fast_ok, "fast_poll off phase")
  // A confirm reports the supply level that matches the settled phase.
  `AADF_ASSERT_SAME(a_confirm_phase, confirm_seen, confirm_ok, "confirm with bad supply")
  // A held sample stays put until it advances.
  `AADF_ASSERT_NEXT(a_sample_kept, in_valid_q && !adv, in_valid_q, "held sample lost")

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for accessory_attach_debounce_fsm: directed poll table, then random
// well-formed attach/detach sequences over several threshold sets. Needs aadf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import aadf_pkg::*;

  // Cycles without any transfer before the run is declared hung
  localparam int unsigned QuietLimit = 2000;
  // Index past the last threshold register; writes there must be ignored
  localparam logic [IdxW-1:0] RegSpare = 3'd7;

  typedef struct packed {
    mv_t  level;
    logic level_bad;
    mv_t  sense;
    logic sense_bad;
  } poll_t;

  // One row of the directed table; typed rows carry their expected status
  typedef struct packed {
    poll_t   smp;
    logic    typed;
    result_t want;
  } poll_row_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [23:0]     s_axis_tdata  = '0;  // [11:0] level_mv, [23:12] sense_mv
  logic [1:0]      s_axis_tuser  = '0;  // [0] level_bad, [1] sense_bad
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // [1:0] phase, [2] supply_on, [3] supply_changed, [4] fast_poll, [7:5] zero
  logic [7:0]      m_axis_tdata;
  logic            cfg_valid_i   = 1'b0;
  logic            cfg_ready_o;
  logic [IdxW-1:0] cfg_index_i   = '0;
  logic [11:0]     cfg_data_i    = '0;

  // Bench-side copy of the block: thresholds, phase, supply enable, poll interval
  mv_t        thresholds [7];
  logic [1:0] phase_now  = PhDetached;
  logic       supply_now = 1'b0;
  logic       fast_now   = 1'b0;

  result_t     expected_status_q [$];
  result_t     predicted_status;
  logic        row_typed = 1'b0;
  result_t     row_want  = '0;
  logic        calm      = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  poll_row_t directed_rows [20];

  accessory_attach_debounce_fsm dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Pick a value in [lo, hi], landing on either edge a quarter of the time
  function automatic mv_t pick_in(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return mv_t'(lo);
    if (r == 1) return mv_t'(hi);
    return mv_t'($urandom_range(hi, lo));
  endfunction

  function automatic poll_row_t mk_row(int unsigned lv, logic lb, int unsigned sv, logic sb,
                                       logic typed, logic [1:0] ph, logic sup, logic chg,
                                       logic fst);
    poll_row_t row;
    row.smp.level     = mv_t'(lv);
    row.smp.level_bad = lb;
    row.smp.sense     = mv_t'(sv);
    row.smp.sense_bad = sb;
    row.typed         = typed;
    row.want          = '{phase: ph, supply_on: sup, supply_changed: chg, fast_poll: fst};
    return row;
  endfunction

  // Advance the debounce machine by one poll sample and return the status it reports
  function automatic result_t advance_debounce(mv_t lv, logic lb, mv_t sv, logic sb);
    logic    att;
    logic    det;
    logic    chg;
    result_t r;
    chg = 1'b0;
    // A failed read on either pin blinds both tests
    if (lb || sb) begin
      att = 1'b0;
      det = 1'b0;
    end else begin
      // Attach thresholds follow the supply state; detach thresholds are fixed
      if (supply_now)
        att = lv >= thresholds[REG_PWR_LEVEL] && sv >= thresholds[REG_PWR_SENSE];
      else
        att = lv >= thresholds[REG_WINDOW_LOW] && lv <= thresholds[REG_WINDOW_HIGH] &&
              sv <= thresholds[REG_UNPWR_SENSE];
      det = lv >= thresholds[REG_RM_LEVEL] && sv <= thresholds[REG_RM_SENSE];
    end
    case (phase_now)
      PhDetached: begin
        if (att) begin
          fast_now  = 1'b1;
          phase_now = PhAttDeb;
        end
      end
      PhAttDeb: begin
        if (att) begin
          fast_now   = 1'b0;
          phase_now  = PhAttached;
          supply_now = 1'b1;
          chg        = 1'b1;
        end else if (det) begin
          // Debounce reversal: back out without touching the supply
          fast_now  = 1'b0;
          phase_now = PhDetached;
        end
      end
      PhAttached: begin
        if (det) begin
          fast_now  = 1'b1;
          phase_now = PhDetDeb;
        end
      end
      default: begin
        if (det) begin
          fast_now   = 1'b0;
          phase_now  = PhDetached;
          supply_now = 1'b0;
          chg        = 1'b1;
        end else if (att) begin
          fast_now  = 1'b0;
          phase_now = PhAttached;
        end
      end
    endcase
    r.phase          = phase_now;
    r.supply_on      = supply_now;
    r.supply_changed = chg;
    r.fast_poll      = fast_now;
    return r;
  endfunction

  // Choose a sample aimed at the tests the machine can take from its present state
  function automatic poll_t pick_poll();
    poll_t       p;
    int unsigned k;
    k = $urandom_range(0, 99);
    p.level_bad = 1'b0;
    p.sense_bad = 1'b0;
    if (k < 40) begin
      // Attach-like sample for the current supply state
      if (supply_now) begin
        p.level = pick_in(thresholds[REG_PWR_LEVEL], 4095);
        p.sense = pick_in(thresholds[REG_PWR_SENSE], 4095);
      end else begin
        p.level = pick_in(thresholds[REG_WINDOW_LOW], thresholds[REG_WINDOW_HIGH]);
        p.sense = pick_in(0, thresholds[REG_UNPWR_SENSE]);
      end
    end else if (k < 75) begin
      p.level = pick_in(thresholds[REG_RM_LEVEL], 4095);
      p.sense = pick_in(0, thresholds[REG_RM_SENSE]);
    end else if (k < 85) begin
      // Plausible reading spoiled by a read error on one or both pins
      p.level     = pick_in(0, 4095);
      p.sense     = pick_in(0, 4095);
      p.level_bad = 1'($urandom_range(0, 1));
      p.sense_bad = !p.level_bad || $urandom_range(0, 1);
    end else begin
      p = poll_t'($urandom);
    end
    return p;
  endfunction

  // Offer one sample and hold it until the transfer; valid stays up for the caller
  task automatic put_sample(input poll_t smp, input logic typed, input result_t want);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp.sense, smp.level};
    s_axis_tuser  <= {smp.sense_bad, smp.level_bad};
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic run_polls(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) put_sample(pick_poll(), 1'b0, '0);
  endtask

  // Drop valid and wait until every expected status has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [IdxW-1:0] idx, input mv_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_RM_SENSE) thresholds[idx] = val;
  endtask

  // Write the full threshold set, plus one write to the spare index that must not land
  task automatic load_thresholds(input mv_t wl, input mv_t wh, input mv_t us, input mv_t pl,
                                 input mv_t ps, input mv_t rl, input mv_t rs);
    write_threshold(REG_WINDOW_LOW, wl);
    write_threshold(REG_WINDOW_HIGH, wh);
    write_threshold(RegSpare, pick_in(0, 4095));
    write_threshold(REG_UNPWR_SENSE, us);
    write_threshold(REG_PWR_LEVEL, pl);
    write_threshold(REG_PWR_SENSE, ps);
    write_threshold(REG_RM_LEVEL, rl);
    write_threshold(REG_RM_SENSE, rs);
    cfg_valid_i <= 1'b0;
  endtask

  // Predict on every accepted sample; typed table rows override the prediction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted_status = advance_debounce(s_axis_tdata[11:0], s_axis_tuser[0],
                                          s_axis_tdata[23:12], s_axis_tuser[1]);
      expected_status_q.push_back(row_typed ? row_want : predicted_status);
    end
  end

  // Check each status transfer against the oldest expectation, then roll next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status transfer: %h", m_axis_tdata);
      end else begin
        result_t want;
        want = expected_status_q.pop_front();
        if (m_axis_tdata[1:0] !== want.phase) begin
          mismatches++;
          if (mismatches <= 10)
            $display("phase: expected %0d, got %0d", want.phase, m_axis_tdata[1:0]);
        end
        if (m_axis_tdata[2] !== want.supply_on) begin
          mismatches++;
          if (mismatches <= 10)
            $display("supply_on: expected %b, got %b", want.supply_on, m_axis_tdata[2]);
        end
        if (m_axis_tdata[3] !== want.supply_changed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("supply_changed: expected %b, got %b", want.supply_changed,
                     m_axis_tdata[3]);
        end
        if (m_axis_tdata[4] !== want.fast_poll) begin
          mismatches++;
          if (mismatches <= 10)
            $display("fast_poll: expected %b, got %b", want.fast_poll, m_axis_tdata[4]);
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
  end

  // Hang detection: count cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("accessory_attach_debounce_fsm regression: fail");
      $finish;
    end
  end

  initial begin
    thresholds[REG_WINDOW_LOW]  = WindowLowRst;
    thresholds[REG_WINDOW_HIGH] = WindowHighRst;
    thresholds[REG_UNPWR_SENSE] = UnpwrSenseRst;
    thresholds[REG_PWR_LEVEL]   = PwrLevelRst;
    thresholds[REG_PWR_SENSE]   = PwrSenseRst;
    thresholds[REG_RM_LEVEL]    = RmLevelRst;
    thresholds[REG_RM_SENSE]    = RmSenseRst;

    // Directed walk under reset thresholds: read errors, extremes, window edges,
    // attach and detach reversals, and both confirms
    directed_rows = '{
      mk_row( 500, 1'b1,    0, 1'b0, 1'b1, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 500, 1'b0,    0, 1'b1, 1'b1, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(   0, 1'b0,    0, 1'b0, 1'b1, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(4095, 1'b0, 4095, 1'b0, 1'b1, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(4095, 1'b0,    0, 1'b0, 1'b1, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 300, 1'b0,    5, 1'b0, 1'b1, PhAttDeb,   1'b0, 1'b0, 1'b1),
      mk_row(3000, 1'b0,   10, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 800, 1'b0,    0, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 801, 1'b0,    0, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 800, 1'b0,    6, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 799, 1'b1,    0, 1'b1, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row( 500, 1'b0,    0, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(2800, 1'b0,    2, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(2800, 1'b0,   11, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(2299, 1'b0,    0, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(2300, 1'b0,   10, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(2300, 1'b1,   10, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(2300, 1'b0,   10, 1'b0, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(   0, 1'b1, 4095, 1'b1, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0),
      mk_row(4095, 1'b1, 4095, 1'b1, 1'b0, PhDetached, 1'b0, 1'b0, 1'b0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      put_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
    run_polls(85);
    settle();

    // Plausible random thresholds
    load_thresholds(pick_in(0, 2000), pick_in(2000, 4095), pick_in(0, 200),
                    pick_in(1500, 4095), pick_in(0, 300), pick_in(1000, 4095),
                    pick_in(0, 300));
    run_polls(85);
    settle();

    // All thresholds at zero, then all at full scale
    load_thresholds('0, '0, '0, '0, '0, '0, '0);
    run_polls(85);
    settle();
    load_thresholds('1, '1, '1, '1, '1, '1, '1);
    run_polls(85);
    settle();

    // Crossed window: the supply-off attach test can never pass
    load_thresholds(12'd3000, 12'd100, pick_in(0, 4095), pick_in(0, 4095),
                    pick_in(0, 4095), pick_in(0, 4095), pick_in(0, 4095));
    run_polls(85);
    settle();

    // Unconstrained thresholds with both streams running flat out
    calm <= 1'b1;
    load_thresholds(pick_in(0, 4095), pick_in(0, 4095), pick_in(0, 4095), pick_in(0, 4095),
                    pick_in(0, 4095), pick_in(0, 4095), pick_in(0, 4095));
    run_polls(85);
    settle();
    calm <= 1'b0;

    // Back to the reset thresholds
    load_thresholds(WindowLowRst, WindowHighRst, UnpwrSenseRst, PwrLevelRst, PwrSenseRst,
                    RmLevelRst, RmSenseRst);
    run_polls(85);
    settle();

    // Allow for a stray late transfer past the pipeline
    repeat (8) @(posedge clk_i);
    mismatches += expected_status_q.size();
    if (mismatches == 0)
      $display("accessory_attach_debounce_fsm regression: pass");
    else
      $display("accessory_attach_debounce_fsm regression: fail");
    $finish;
  end

endmodule
